// File: design/lcdt_pkg.sv
package lcdt_pkg;

	localparam int TICK_W  = 8;
	localparam int ACC_W   = 10;
	localparam int LINE_W  = 8;
	localparam int CMP_W   = 8;
	localparam int IRQEN_W = 4;
	localparam int CFG_W   = 8;

	localparam logic [ACC_W-1:0] OAM_CYCLES    = ACC_W'(80);
	localparam logic [ACC_W-1:0] XFER_CYCLES   = ACC_W'(172);
	localparam logic [ACC_W-1:0] HBLANK_CYCLES = ACC_W'(204);
	localparam logic [ACC_W-1:0] LINE_CYCLES   = ACC_W'(456);

	localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
	localparam logic [LINE_W-1:0] LAST_LINE         = LINE_W'(152);

	// bit positions in the interrupt source enable register
	localparam int IRQEN_HBLANK = 0;
	localparam int IRQEN_VBLANK = 1;
	localparam int IRQEN_OAM    = 2;
	localparam int IRQEN_MATCH  = 3;

	typedef enum logic {
		REG_LINE_COMPARE = 1'b0,
		REG_IRQ_ENABLES  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_HBL  = 2'd0,
		MODE_VBL  = 2'd1,
		MODE_SCAN = 2'd2,
		MODE_XFER = 2'd3
	} lcd_mode_t;

	typedef struct packed {
		lcd_mode_t         mode;
		logic [LINE_W-1:0] line;
		logic              match;
		logic              irq;
		logic              vblank;
		logic              render;
		logic              running;
	} result_t;

endpackage

// File: design/lcd_mode_timing_top.sv
// An accepted word is held in the input stage; its status is registered into the result stage.
// Throughput: one word per cycle when not stalled; the next word uses the state left
// by the previous one, updated by the single step stage in the cycle it completes.
// Reset (arst_n low, asynchronous): timing off, hblank, line 0, accumulator
// and both configuration registers cleared, both pipeline stages emptied.
module lcd_mode_timing_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lcdt_pkg::TICK_W-1:0]   tick_cycles,
	input  logic                          display_on,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    lcd_mode,
	output logic [lcdt_pkg::LINE_W-1:0]   scan_line,
	output logic                          line_match,
	output logic                          lcd_irq,
	output logic                          vblank_irq,
	output logic                          render_line,
	output logic                          running,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [lcdt_pkg::CFG_W-1:0]    cfg_wdata
);
	import lcdt_pkg::*;

	logic                valid_s1, out_valid_q, adv_s2, ld_s1;
	logic [TICK_W-1:0]   tick_s1;
	logic                on_s1;
	logic [CMP_W-1:0]    line_compare_q;
	logic [IRQEN_W-1:0]  irq_enables_q;
	result_t             res, res_s2;

	assign adv_s2   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign ld_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) valid_s1 <= 1'b1;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			tick_s1 <= tick_cycles;
			on_s1   <= display_on;
		end
		if (adv_s2 && valid_s1) res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_compare_q <= '0;
			irq_enables_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_LINE_COMPARE: line_compare_q <= cfg_wdata[CMP_W-1:0];
				REG_IRQ_ENABLES:  irq_enables_q  <= cfg_wdata[IRQEN_W-1:0];
				default: ;
			endcase
		end
	end

	lcdt_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (valid_s1 && adv_s2),
		.tick         (tick_s1),
		.on           (on_s1),
		.line_compare (line_compare_q),
		.irq_enables  (irq_enables_q),
		.result       (res)
	);

	assign out_valid   = out_valid_q;
	assign lcd_mode    = res_s2.mode;
	assign scan_line   = res_s2.line;
	assign line_match  = res_s2.match;
	assign lcd_irq     = res_s2.irq;
	assign vblank_irq  = res_s2.vblank;
	assign render_line = res_s2.render;
	assign running     = res_s2.running;

endmodule

// File: design/lcdt_core.sv
module lcdt_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic [lcdt_pkg::TICK_W-1:0] tick,
	input  logic                        on,
	input  logic [lcdt_pkg::CMP_W-1:0]  line_compare,
	input  logic [lcdt_pkg::IRQEN_W-1:0] irq_enables,
	output lcdt_pkg::result_t           result
);
	import lcdt_pkg::*;

	logic [ACC_W-1:0]  accum_q, accum_d, acc_base, acc_sat, acc_new;
	logic [ACC_W:0]    acc_sum;
	logic              timing_q, timing_d;
	lcd_mode_t         mode_q, mode_d, mode_base, mode_new;
	logic [LINE_W-1:0] line_q, line_d, line_base, line_new, line_inc;
	logic              turn_off, match, vbl, rend;

	always_comb begin
		turn_off  = timing_q && !on;
		acc_base  = (timing_q && on) ? accum_q : '0;
		mode_base = turn_off ? MODE_HBL : mode_q;
		line_base = turn_off ? '0 : line_q;
		timing_d  = on;
		acc_sum   = {1'b0, acc_base} + {{(ACC_W + 1 - TICK_W){1'b0}}, tick};
		// saturate before the mode compare
		acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
		line_inc  = line_base + LINE_W'(1);
	end

	always_comb begin
		acc_new  = acc_sat;
		mode_new = mode_base;
		line_new = line_base;
		vbl      = 1'b0;
		rend     = 1'b0;
		unique case (mode_base)
			MODE_SCAN: begin
				if (acc_sat >= OAM_CYCLES) begin
					acc_new  = acc_sat - OAM_CYCLES;
					mode_new = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (acc_sat >= XFER_CYCLES) begin
					acc_new  = acc_sat - XFER_CYCLES;
					mode_new = MODE_HBL;
					rend     = 1'b1;
				end
			end
			MODE_HBL: begin
				if (acc_sat >= HBLANK_CYCLES) begin
					acc_new  = acc_sat - HBLANK_CYCLES;
					line_new = line_inc;
					if (line_inc == FIRST_VBLANK_LINE) begin
						vbl      = 1'b1;
						mode_new = MODE_VBL;
					end else begin
						mode_new = MODE_SCAN;
					end
				end
			end
			MODE_VBL: begin
				if (acc_sat >= LINE_CYCLES) begin
					acc_new = acc_sat - LINE_CYCLES;
					// wrap at the last line; line 0 leaves vblank a period later
					priority if (line_base == LAST_LINE) line_new = '0;
					else if (line_base == '0) mode_new = MODE_SCAN;
					else line_new = line_inc;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		match = (line_new == line_compare);
		if (on) begin
			accum_d = acc_new;
			mode_d  = mode_new;
			line_d  = line_new;
		end else begin
			accum_d = '0;
			mode_d  = mode_base;
			line_d  = line_base;
		end
		result.mode    = mode_d;
		result.line    = line_d;
		result.running = timing_d;
		result.match   = on && match;
		result.irq     = on && ((match && irq_enables[IRQEN_MATCH]) ||
			(mode_new == MODE_SCAN && irq_enables[IRQEN_OAM]) ||
			(mode_new == MODE_VBL  && irq_enables[IRQEN_VBLANK]) ||
			(mode_new == MODE_HBL  && irq_enables[IRQEN_HBLANK]));
		result.vblank  = on && vbl;
		result.render  = on && rend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			timing_q <= 1'b0;
			mode_q   <= MODE_HBL;
			line_q   <= '0;
		end else if (step_en) begin
			accum_q  <= accum_d;
			timing_q <= timing_d;
			mode_q   <= mode_d;
			line_q   <= line_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!timing_q |-> (mode_q == MODE_HBL && line_q == '0 && accum_q == '0))
		else $error("timing off but state not cleared");
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LAST_LINE)
		else $error("scan line beyond last line");
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.vblank |=> (line_q == FIRST_VBLANK_LINE && mode_q == MODE_VBL))
		else $error("vblank pulse without entering vblank at its first line");
`endif
endmodule
